/* hdl/tpq_pkg.sv */
// Shared types, constants and helper functions for the thread priority queue.
`timescale 1ns / 1ps

package tpq_pkg;

   // Queue dimensions.
   localparam int CAPACITY   = 16;
   localparam int ID_BITS    = 8;
   localparam int PRIO_BITS  = 16;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // Fixed widths of the port fields.
   localparam int CMD_W    = 3;
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 5;

   // Wide enough to hold any priority range and the request field.
   localparam int WIDE_W = 34;

   localparam logic signed [WIDE_W-1:0] PRIO_MAX_WIDE =
      (WIDE_W'(1) <<< (PRIO_BITS - 1)) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] PRIO_MIN_WIDE = -PRIO_MAX_WIDE - WIDE_W'(1);
   localparam logic signed [PRIO_BITS-1:0] PRIO_MAX = PRIO_BITS'(PRIO_MAX_WIDE);
   localparam logic signed [PRIO_BITS-1:0] PRIO_MIN = PRIO_BITS'(PRIO_MIN_WIDE);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT       = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_POP_MAX      = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_DELETE       = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_FAVORITE     = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_INCREASE_ALL = CMD_W'(4);
   localparam logic [CMD_W-1:0] CMD_CONTAINS     = CMD_W'(5);

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] STATUS_FULL      = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = STATUS_W'(4);

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [ID_W-1:0]          thread_id;
      logic signed [PRIO_W-1:0] priority_req;
   } tpq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          out_id;
      logic signed [PRIO_W-1:0] out_priority;
      logic [TOTAL_W-1:0]       entry_total;
   } tpq_rsp_type;

   // One queue entry as held in a cell.
   typedef struct packed {
      logic [ID_BITS-1:0]          id;
      logic signed [PRIO_BITS-1:0] prio;
   } tpq_entry_type;

   // What every cell does in the current cycle.
   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_INSERT,
      MODE_REMOVE,
      MODE_FAVORITE,
      MODE_INCREMENT
   } tpq_mode_type;

   // Control broadcast from the queue controller to all cells.
   typedef struct packed {
      tpq_mode_type                mode;
      logic signed [PRIO_BITS-1:0] prio;
      logic                        take_head;
   } tpq_bcast_type;

   // Saturates a request priority into the stored priority range.
   function automatic logic signed [PRIO_BITS-1:0] clamp_prio(
      input logic signed [PRIO_W-1:0] value
   );
      logic signed [WIDE_W-1:0] wide;
      wide = WIDE_W'(value);
      if (wide > PRIO_MAX_WIDE) begin
         return PRIO_MAX;
      end
      if (wide < PRIO_MIN_WIDE) begin
         return PRIO_MIN;
      end
      return PRIO_BITS'(wide);
   endfunction

   // Adds one, holding at the largest priority.
   function automatic logic signed [PRIO_BITS-1:0] incr_sat(
      input logic signed [PRIO_BITS-1:0] value
   );
      if (value == PRIO_MAX) begin
         return value;
      end
      return value + PRIO_BITS'(1);
   endfunction

endpackage

/* hdl/tpq_cell.sv */
// One position of the sorted queue: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module tpq_cell import tpq_pkg::*; (
   input  logic          clock,
   input  tpq_bcast_type bcast,
   input  logic [ID_BITS-1:0] key_id,
   input  logic          head,
   input  logic          occupied,
   input  logic          prev_ge,
   input  logic          seen_in,
   input  tpq_entry_type prev_entry,
   input  tpq_entry_type next_entry,
   output logic          match,
   output logic          ge,
   output logic          seen_out,
   output tpq_entry_type entry
);

   tpq_entry_type entry_ff;
   tpq_entry_type entry_in;

   assign match    = occupied && (entry_ff.id == key_id);
   assign ge       = occupied && ($signed(entry_ff.prio) >= $signed(bcast.prio));
   assign seen_out = seen_in || match;
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (bcast.mode)
         MODE_INSERT: begin
            // Entries with a lower priority than the new one move one place towards the tail.
            if (!prev_ge) begin
               entry_in = prev_entry;
            end else if (!ge) begin
               entry_in.id   = key_id;
               entry_in.prio = bcast.prio;
            end
         end
         MODE_REMOVE: begin
            if (seen_in || match) begin
               entry_in = next_entry;
            end
         end
         MODE_FAVORITE: begin
            // Everything up to the old place of the entry moves down to free the head.
            if (head) begin
               entry_in.id   = key_id;
               entry_in.prio = bcast.prio;
            end else if (!seen_in) begin
               entry_in = prev_entry;
            end
         end
         MODE_INCREMENT: begin
            entry_in.prio = incr_sat(entry_ff.prio);
         end
         MODE_NONE: begin
            entry_in = entry_ff;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* hdl/thread_priority_queue.sv */
// Top level of the thread priority queue: command control and the chain of cells.
//
//   Channel   Ports                         Direction  Transfer when
//   request   start, busy, req_data         in         start high and busy low at a clock edge
//   response  rsp_strobe, rsp_data          out        every cycle in which rsp_strobe is high
//
// A command is registered at the transfer, and in the following cycle every cell compares
// its entry against the broadcast id and priority and shifts, loads or holds at the end of
// that cycle. The result is shown the cycle after, while the next command can already be
// taken, so a new command is accepted only once the last one has executed.
// Reset clears the entry count, busy and the result strobe; the cells need no clearing.
// The receiver cannot stall: each result is on rsp_data for exactly one cycle.
`timescale 1ns / 1ps

module thread_priority_queue import tpq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tpq_req_type req_data,
   output logic        rsp_strobe,
   output tpq_rsp_type rsp_data
);

   logic                  busy_ff;
   logic                  busy_in;
   logic                  rsp_strobe_ff;
   logic                  rsp_strobe_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   tpq_req_type           req_ff;
   tpq_req_type           req_in;
   tpq_rsp_type           rsp_ff;
   tpq_rsp_type           rsp_in;

   tpq_bcast_type         bcast;
   logic [ID_BITS-1:0]    key_id;
   logic [CAPACITY-1:0]   match_vec;
   logic [CAPACITY-1:0]   ge_vec;
   logic [CAPACITY:0]     seen_vec;
   logic                  any_match;
   tpq_entry_type         entries [CAPACITY];

   assign key_id    = req_ff.thread_id[ID_BITS-1:0];
   assign any_match = |match_vec;
   assign seen_vec[0] = bcast.take_head;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      tpq_entry_type prev_e;
      tpq_entry_type next_e;
      logic          prev_ge_w;
      logic          occupied_w;

      assign occupied_w = (COUNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_e    = '0;
         assign prev_ge_w = 1'b1;
      end else begin : g_body
         assign prev_e    = entries[i-1];
         assign prev_ge_w = ge_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = entries[i+1];
      end

      tpq_cell u_cell (
         .clock      (clock),
         .bcast      (bcast),
         .key_id     (key_id),
         .head       (i == 0),
         .occupied   (occupied_w),
         .prev_ge    (prev_ge_w),
         .seen_in    (seen_vec[i]),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .match      (match_vec[i]),
         .ge         (ge_vec[i]),
         .seen_out   (seen_vec[i+1]),
         .entry      (entries[i])
      );
   end

   assign busy_in       = start && !busy_ff;
   assign rsp_strobe_in = busy_ff;
   assign req_in        = busy_in ? req_data : req_ff;

   always_comb begin
      bcast.mode      = MODE_NONE;
      bcast.prio      = clamp_prio(req_ff.priority_req);
      bcast.take_head = 1'b0;
      count_in        = count_ff;
      rsp_in.status       = STATUS_OK;
      rsp_in.out_id       = ID_W'(key_id);
      rsp_in.out_priority = '0;

      unique case (req_ff.command)
         CMD_INSERT: begin
            // The duplicate check takes precedence over the full check.
            if (any_match) begin
               rsp_in.status = STATUS_DUPLICATE;
            end else if (count_ff == COUNT_BITS'(CAPACITY)) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               bcast.mode = MODE_INSERT;
               count_in   = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_POP_MAX: begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               bcast.mode          = MODE_REMOVE;
               bcast.take_head     = 1'b1;
               count_in            = count_ff - COUNT_BITS'(1);
               rsp_in.out_id       = ID_W'(entries[0].id);
               rsp_in.out_priority = PRIO_W'($signed(entries[0].prio));
            end
         end
         CMD_DELETE: begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else if (!any_match) begin
               rsp_in.status = STATUS_NOT_FOUND;
            end else begin
               bcast.mode = MODE_REMOVE;
               count_in   = count_ff - COUNT_BITS'(1);
            end
         end
         CMD_FAVORITE: begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else if (!any_match) begin
               rsp_in.status = STATUS_NOT_FOUND;
            end else if (count_ff != COUNT_BITS'(1)) begin
               // The head after removal is the second entry when the favourite was the head.
               bcast.mode = MODE_FAVORITE;
               bcast.prio = incr_sat(match_vec[0] ? entries[1].prio : entries[0].prio);
            end
         end
         CMD_INCREASE_ALL: begin
            bcast.mode = MODE_INCREMENT;
         end
         CMD_CONTAINS: begin
            if (!any_match) begin
               rsp_in.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            rsp_in.status = STATUS_OK;
         end
      endcase

      rsp_in.entry_total = TOTAL_W'(count_in);

      if (!busy_ff) begin
         bcast.mode      = MODE_NONE;
         bcast.take_head = 1'b0;
         count_in        = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every command yields its result in the cycle after it executes.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_strobe_ff && !busy_ff)
      else $error("result strobe missing after an executed command");

   // Queued ids are unique, so at most one cell can match.
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(match_vec))
      else $error("more than one cell holds the same id");

   // A removal always finds the entry it takes out.
   a_remove_found: assert property (@(posedge clock) disable iff (reset)
      bcast.mode == MODE_REMOVE |-> seen_vec[CAPACITY])
      else $error("removal without a matching entry");

   // An insertion never pushes an occupied entry off the tail.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      bcast.mode == MODE_INSERT |-> !ge_vec[CAPACITY-1] && (count_ff < COUNT_BITS'(CAPACITY)))
      else $error("insertion into a full queue");

   // The reported total matches the entry count after the command.
   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> rsp_ff.entry_total == TOTAL_W'(count_ff))
      else $error("reported entry total differs from the entry count");

endmodule
